/* sv/pacc_pkg.sv */
// Shared types and constants for the pointer acceleration power curve block.
package pacc_pkg;

  localparam int DEF_TABLE_ENTRIES = 128;
  localparam int DEF_FRACTION_BITS = 8;

  localparam int VALUE_W    = 16;
  localparam int EXP_W      = 10;
  localparam int BUILT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [EXP_W-1:0]   EXP_RESET    = 10'd120;
  localparam logic               REM_EN_RESET = 1'b1;
  localparam logic [BUILT_W-1:0] BUILT_RESET  = 11'd2047;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REMAINDER  = 2'd1;

  // Exponent to Q16 power: (e * 65536 + 50) / 100 by reciprocal multiplication.
  // The reciprocal is exact for every numerator below 2^26.
  localparam int DIV_W     = 26;
  localparam int RECIP_W   = 27;
  localparam int DIV_SHIFT = 33;
  localparam int QUO_W     = DIV_W + RECIP_W - DIV_SHIFT;
  localparam int DIV_BIAS  = 50;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd85899346;

  // Shared multiplier.
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int Y_W    = PROD_W - 16;

  localparam logic signed [MUL_W-1:0] Q16_ONE = 25'sd65536;
  localparam logic signed [MUL_W-1:0] LOG_C0  = -25'sd114150;
  localparam logic signed [MUL_W-1:0] LOG_C1  = 25'sd184890;
  localparam logic signed [MUL_W-1:0] LOG_C2  = -25'sd96335;
  localparam logic signed [MUL_W-1:0] LOG_C3  = 25'sd29306;
  localparam logic signed [MUL_W-1:0] EXP_E1  = 25'sd45426;
  localparam logic signed [MUL_W-1:0] EXP_E2  = 25'sd15743;
  localparam logic signed [MUL_W-1:0] EXP_E3  = 25'sd3657;
  localparam int YI_SAT = 30;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_NEXT, ST_L2, ST_L3, ST_L4, ST_Y,
    ST_E1, ST_E2, ST_E3, ST_WR, ST_LK, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_M_C3, MUL_M_T1, MUL_M_T2, MUL_P_ARG,
    MUL_F_E3, MUL_F_T3, MUL_F_T4, MUL_SLOPE_DIST
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     accept;
    logic     div_init;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     y_load;
    logic     wr_entry;
    logic     lk_read;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic pass;
    logic need_build;
    logic d_small;
    logic d_last;
    logic out_free;
  } status_t;

endpackage

/* sv/pacc_ctrl.sv */
// Sequencer for table rebuild, lookup and result hand-off.
module pacc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  pacc_pkg::status_t sts,
  output pacc_pkg::cmd_t    cmd
);

  pacc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pacc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pacc_pkg::ST_IDLE: if (in_tvalid) state_nxt = pacc_pkg::ST_DEC;
      pacc_pkg::ST_DEC: begin
        if (sts.pass) state_nxt = pacc_pkg::ST_OUT;
        else if (sts.need_build) state_nxt = pacc_pkg::ST_NEXT;
        else state_nxt = pacc_pkg::ST_LK;
      end
      pacc_pkg::ST_NEXT: state_nxt = sts.d_small ? pacc_pkg::ST_WR : pacc_pkg::ST_L2;
      pacc_pkg::ST_L2:   state_nxt = pacc_pkg::ST_L3;
      pacc_pkg::ST_L3:   state_nxt = pacc_pkg::ST_L4;
      pacc_pkg::ST_L4:   state_nxt = pacc_pkg::ST_Y;
      pacc_pkg::ST_Y:    state_nxt = pacc_pkg::ST_E1;
      pacc_pkg::ST_E1:   state_nxt = pacc_pkg::ST_E2;
      pacc_pkg::ST_E2:   state_nxt = pacc_pkg::ST_E3;
      pacc_pkg::ST_E3:   state_nxt = pacc_pkg::ST_WR;
      pacc_pkg::ST_WR:   state_nxt = sts.d_last ? pacc_pkg::ST_LK : pacc_pkg::ST_NEXT;
      pacc_pkg::ST_LK:   state_nxt = pacc_pkg::ST_OUT;
      pacc_pkg::ST_OUT:  if (sts.out_free) state_nxt = pacc_pkg::ST_IDLE;
      default:           state_nxt = pacc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = pacc_pkg::MUL_M_C3;
    case (state_r)
      pacc_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = in_tvalid;
      end
      pacc_pkg::ST_DEC:  cmd.div_init = !sts.pass && sts.need_build;
      pacc_pkg::ST_NEXT: cmd.mul_en = 1'b1;
      pacc_pkg::ST_L2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = pacc_pkg::MUL_M_T1;
      end
      pacc_pkg::ST_L3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = pacc_pkg::MUL_M_T2;
      end
      pacc_pkg::ST_L4: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = pacc_pkg::MUL_P_ARG;
      end
      pacc_pkg::ST_Y:    cmd.y_load = 1'b1;
      pacc_pkg::ST_E1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = pacc_pkg::MUL_F_E3;
      end
      pacc_pkg::ST_E2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = pacc_pkg::MUL_F_T3;
      end
      pacc_pkg::ST_E3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = pacc_pkg::MUL_F_T4;
      end
      pacc_pkg::ST_WR:   cmd.wr_entry = 1'b1;
      pacc_pkg::ST_LK: begin
        cmd.lk_read = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pacc_pkg::MUL_SLOPE_DIST;
      end
      pacc_pkg::ST_OUT:  cmd.load_out = sts.out_free;
      default:           cmd.in_ready = 1'b0;
    endcase
  end

endmodule

/* sv/pacc_dp.sv */
// Datapath: configuration, curve table memory, shared multiplier and output register.
module pacc_dp #(
  parameter int TABLE_ENTRIES = pacc_pkg::DEF_TABLE_ENTRIES,
  parameter int FRACTION_BITS = pacc_pkg::DEF_FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pacc_pkg::cmd_t                       cmd,
  output pacc_pkg::status_t                    sts,
  input  logic [1:0]                           in_tuser,
  input  logic [pacc_pkg::VALUE_W-1:0]         in_tdata,
  input  logic                                 cfg_valid,
  input  logic [pacc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pacc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [pacc_pkg::VALUE_W-1:0]         out_tdata,
  output logic                                 out_tuser
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int NW    = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int SH    = 16 - FRACTION_BITS;
  localparam int MW    = pacc_pkg::MUL_W;
  localparam int PW    = pacc_pkg::PROD_W;
  localparam int YW    = pacc_pkg::Y_W;
  localparam int DPW   = pacc_pkg::DIV_W + pacc_pkg::RECIP_W;
  localparam int ACC_W = 34;
  localparam int WH_W  = ACC_W - FRACTION_BITS;
  localparam logic [14:0] N15    = 15'(TABLE_ENTRIES);
  localparam logic [14:0] NM1_15 = 15'(TABLE_ENTRIES - 1);

  logic [pacc_pkg::EXP_W-1:0]   exp_r;
  logic                         rem_en_r;
  logic [pacc_pkg::BUILT_W-1:0] built_r;
  logic                         kind_r, axis_r;
  logic signed [15:0]           val_r;
  logic [pacc_pkg::QUO_W-1:0]   dq_r;
  logic [IDX_W:0]               d_r;
  logic signed [PW-1:0]         prod_r;
  logic [YW-1:0]                y_r;
  logic [15:0]                  last_r, prev_r, rdata_r;
  logic                         range_r;
  logic [15:0]                  curve_mem [TABLE_ENTRIES];
  logic [FRACTION_BITS-1:0]     rem_r [2];
  logic                         out_valid_r, out_pass_r;
  logic [15:0]                  out_data_r;

  // Q16 power from the exponent: biased numerator times the reciprocal of 100.
  logic [pacc_pkg::DIV_W-1:0] div_num;
  logic [DPW-1:0]             div_prod;
  assign div_num  = {exp_r, 16'b0} + pacc_pkg::DIV_W'(pacc_pkg::DIV_BIAS);
  assign div_prod = {{pacc_pkg::RECIP_W{1'b0}}, div_num}
                  * {{pacc_pkg::DIV_W{1'b0}}, pacc_pkg::DIV_RECIP};

  logic [IDX_W-1:0] d_idx;
  logic [NW-1:0]    n;
  logic [IDX_W+15:0] m_wide;
  logic [16:0]      m;
  assign d_idx  = d_r[IDX_W-1:0];

  always_comb begin
    n = '0;
    for (int i = 1; i < IDX_W; i++) begin
      if (d_idx[i]) n = NW'(i);
    end
  end
  assign m_wide = {d_idx, 16'b0} >> n;
  assign m      = m_wide[16:0];

  // Q16 product truncated toward zero.
  logic signed [PW-1:0] prod_bias, tr_full;
  logic signed [MW-1:0] tr_n;
  assign prod_bias = prod_r + (prod_r[PW-1] ? PW'(65535) : PW'(0));
  assign tr_full   = prod_bias >>> 16;
  assign tr_n      = tr_full[MW-1:0];

  logic signed [MW-1:0] p_q16, m_s, f_s, n_arg;
  assign p_q16 = (dq_r < pacc_pkg::QUO_W'(65536)) ? pacc_pkg::Q16_ONE
               : signed'(MW'(dq_r));
  assign m_s   = signed'(MW'(m));
  assign f_s   = signed'(MW'(y_r[15:0]));
  assign n_arg = signed'(MW'({n, 16'b0})) + pacc_pkg::LOG_C0 + tr_n;

  // Lookup magnitude.
  logic [15:0] abs16, slope;
  logic [14:0] d_in, ext_span;
  logic        in_range;
  assign abs16    = val_r[15] ? (16'd0 - val_r) : val_r;
  assign d_in     = abs16[15] ? 15'h7FFF : abs16[14:0];
  assign in_range = d_in < N15;
  assign ext_span = d_in - NM1_15;
  assign slope    = last_r - prev_r;

  logic signed [MW-1:0] mul_a, mul_b;
  always_comb begin
    case (cmd.mul_sel)
      pacc_pkg::MUL_M_C3: begin mul_a = m_s; mul_b = pacc_pkg::LOG_C3; end
      pacc_pkg::MUL_M_T1: begin mul_a = m_s; mul_b = pacc_pkg::LOG_C2 + tr_n; end
      pacc_pkg::MUL_M_T2: begin mul_a = m_s; mul_b = pacc_pkg::LOG_C1 + tr_n; end
      pacc_pkg::MUL_P_ARG: begin mul_a = p_q16; mul_b = n_arg; end
      pacc_pkg::MUL_F_E3: begin mul_a = f_s; mul_b = pacc_pkg::EXP_E3; end
      pacc_pkg::MUL_F_T3: begin mul_a = f_s; mul_b = pacc_pkg::EXP_E2 + tr_n; end
      pacc_pkg::MUL_F_T4: begin mul_a = f_s; mul_b = pacc_pkg::EXP_E1 + tr_n; end
      pacc_pkg::MUL_SLOPE_DIST: begin
        mul_a = signed'(MW'(slope));
        mul_b = signed'(MW'(ext_span));
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Table entry: q scaled by 2^yi, rounded to FRACTION_BITS and saturated.
  logic [17:0] yi;
  logic        yi_sat;
  logic [MW-1:0] q_full;
  logic [47:0] scaled, rounded, r_val;
  logic [15:0] entry;
  assign yi      = y_r[YW-1:16];
  assign yi_sat  = yi >= 18'(pacc_pkg::YI_SAT);
  assign q_full  = MW'(pacc_pkg::Q16_ONE + tr_n);
  assign scaled  = {30'b0, q_full[17:0]} << yi[4:0];
  assign rounded = scaled + (48'd1 << (SH - 1));
  assign r_val   = rounded >> SH;

  always_comb begin
    if (d_idx == '0) entry = '0;
    else if (d_idx == IDX_W'(1)) entry = 16'(1 << FRACTION_BITS);
    else if (yi_sat || (r_val > 48'd65535)) entry = 16'hFFFF;
    else entry = r_val[15:0];
  end

  // Result: signed magnitude plus remainder, floor-shifted and saturated.
  logic [31:0] mag;
  logic signed [ACC_W-1:0] acc, smag;
  logic signed [WH_W-1:0] whole;
  logic [15:0] res;
  assign mag  = range_r ? {16'b0, rdata_r} : ({16'b0, last_r} + prod_r[31:0]);
  assign smag = val_r[15] ? -signed'(ACC_W'(mag)) : signed'(ACC_W'(mag));
  assign acc  = smag + (rem_en_r ? signed'(ACC_W'(rem_r[axis_r])) : ACC_W'(0));
  assign whole = WH_W'(acc >>> FRACTION_BITS);

  always_comb begin
    if (whole > WH_W'(32767)) res = 16'h7FFF;
    else if (whole < -signed'(WH_W'(32768))) res = 16'h8000;
    else res = whole[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= pacc_pkg::EXP_RESET;
      rem_en_r    <= pacc_pkg::REM_EN_RESET;
      built_r     <= pacc_pkg::BUILT_RESET;
      rem_r[0]    <= '0;
      rem_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pacc_pkg::REG_EXPONENT:  exp_r    <= cfg_data;
          pacc_pkg::REG_REMAINDER: rem_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.div_init) built_r <= {1'b0, exp_r};
      if (cmd.load_out && !kind_r && rem_en_r) rem_r[axis_r] <= acc[FRACTION_BITS-1:0];
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_tuser[0];
      axis_r <= in_tuser[1];
      val_r  <= in_tdata;
    end
    if (cmd.div_init) begin
      dq_r <= div_prod[DPW-1:pacc_pkg::DIV_SHIFT];
      d_r  <= '0;
    end else if (cmd.wr_entry) begin
      d_r <= d_r + 1'b1;
    end
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    if (cmd.y_load) y_r <= tr_full[PW-1] ? '0 : YW'(tr_full);
    if (cmd.wr_entry) begin
      curve_mem[d_idx] <= entry;
      if (d_idx == IDX_W'(TABLE_ENTRIES - 1)) last_r <= entry;
      if (d_idx == IDX_W'(TABLE_ENTRIES - 2)) prev_r <= entry;
    end
    if (cmd.lk_read) begin
      rdata_r <= curve_mem[in_range ? d_in[IDX_W-1:0] : '0];
      range_r <= in_range;
    end
    if (cmd.load_out) begin
      out_data_r <= kind_r ? val_r : res;
      out_pass_r <= kind_r;
    end
  end

  assign sts.pass       = kind_r;
  assign sts.need_build = built_r != {1'b0, exp_r};
  assign sts.d_small    = d_idx < IDX_W'(2);
  assign sts.d_last     = d_idx == IDX_W'(TABLE_ENTRIES - 1);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_pass_r;

endmodule

/* sv/pointer_accel_power_curve.sv */
// A motion item steps through accept, decode, table read and result when the curve
// table is current; a passed-through item skips the table read. After reset or an
// exponent change the first motion item first rebuilds the table, one entry at a time
// through the shared multiplier sequence (the first two entries skip the sequence).
// The next item is accepted while a result waits in the output register.
// Results are sign(v)*|v|^P in whole counts with a carried per-axis sub-count.
module pointer_accel_power_curve #(
  parameter int TABLE_ENTRIES = pacc_pkg::DEF_TABLE_ENTRIES,
  parameter int FRACTION_BITS = pacc_pkg::DEF_FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // motion_value
  input  logic [1:0]                      in_tuser,   // kind, axis
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // result_value
  output logic                            out_tuser,  // was_passed_through
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pacc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pacc_pkg::CFG_DATA_W-1:0] cfg_data
);

  pacc_pkg::cmd_t    cmd;
  pacc_pkg::status_t sts;

  assign in_tready = cmd.in_ready;
  assign cfg_ready = 1'b1;

  pacc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  pacc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* sv/pacc_checker.sv */
// Port-level checks for the pointer acceleration block, bound to the top level.
module pacc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous item in work");

endmodule

bind pointer_accel_power_curve pacc_checker u_pacc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
